// ----- design/acc_cpu_pkg.sv -----
package acc_cpu_pkg;

   localparam int MEM_DEPTH  = 4096;
   localparam int MEM_ADDR_W = $clog2(MEM_DEPTH);

   localparam int WORD_W    = 32;
   localparam int PLEN_W    = 13;
   localparam int OPN_W     = 2;
   localparam int OPC_W     = 8;
   localparam int OPERAND_W = 24;
   localparam int LADDR_W   = 12;
   localparam int STATUS_W  = 2;

   localparam logic [OPN_W-1:0] OPN_EXEC = 2'd0;
   localparam logic [OPN_W-1:0] OPN_LOAD = 2'd1;
   localparam logic [OPN_W-1:0] OPN_SKIP = 2'd2;

   localparam logic [STATUS_W-1:0] ST_RUN   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_END   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FAULT = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADOP = 2'd3;

   localparam logic [OPC_W-1:0] OPC_LDC    = 8'h00;
   localparam logic [OPC_W-1:0] OPC_ADC    = 8'h01;
   localparam logic [OPC_W-1:0] OPC_LDL    = 8'h02;
   localparam logic [OPC_W-1:0] OPC_STL    = 8'h03;
   localparam logic [OPC_W-1:0] OPC_LDNL   = 8'h04;
   localparam logic [OPC_W-1:0] OPC_STNL   = 8'h05;
   localparam logic [OPC_W-1:0] OPC_ADD    = 8'h06;
   localparam logic [OPC_W-1:0] OPC_SUB    = 8'h07;
   localparam logic [OPC_W-1:0] OPC_SHL    = 8'h08;
   localparam logic [OPC_W-1:0] OPC_SHR    = 8'h09;
   localparam logic [OPC_W-1:0] OPC_ADJ    = 8'h0A;
   localparam logic [OPC_W-1:0] OPC_A2SP   = 8'h0B;
   localparam logic [OPC_W-1:0] OPC_SP2A   = 8'h0C;
   localparam logic [OPC_W-1:0] OPC_CALL   = 8'h0D;
   localparam logic [OPC_W-1:0] OPC_RETURN = 8'h0E;
   localparam logic [OPC_W-1:0] OPC_BRZ    = 8'h0F;
   localparam logic [OPC_W-1:0] OPC_BRLZ   = 8'h10;
   localparam logic [OPC_W-1:0] OPC_BR     = 8'h11;
   localparam logic [OPC_W-1:0] OPC_HALT   = 8'h12;

   typedef struct packed {
      logic [OPN_W-1:0]            operation;
      logic [OPC_W-1:0]            instr_opcode;
      logic signed [OPERAND_W-1:0] instr_operand;
      logic [LADDR_W-1:0]          load_address;
      logic signed [WORD_W-1:0]    load_data;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   a;
      logic [WORD_W-1:0]   b;
      logic [WORD_W-1:0]   sp;
      logic [WORD_W-1:0]   pc;
   } cpu_state_type;

   typedef struct packed {
      logic                  en;
      logic [MEM_ADDR_W-1:0] addr;
      logic [WORD_W-1:0]     data;
   } mem_wr_type;

endpackage

// ----- design/acc_cpu_if.sv -----
interface acc_cpu_req_if;
   logic                                          valid;
   logic                                          ready;
   logic [acc_cpu_pkg::OPN_W-1:0]                 operation;
   logic [acc_cpu_pkg::OPC_W-1:0]                 instr_opcode;
   logic signed [acc_cpu_pkg::OPERAND_W-1:0]      instr_operand;
   logic [acc_cpu_pkg::LADDR_W-1:0]               load_address;
   logic signed [acc_cpu_pkg::WORD_W-1:0]         load_data;

   modport source(output valid, output operation, output instr_opcode, output instr_operand,
                  output load_address, output load_data, input ready);
   modport sink(input valid, input operation, input instr_opcode, input instr_operand,
                input load_address, input load_data, output ready);
endinterface

interface acc_cpu_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [acc_cpu_pkg::STATUS_W-1:0]      status;
   logic signed [acc_cpu_pkg::WORD_W-1:0] reg_a;
   logic signed [acc_cpu_pkg::WORD_W-1:0] reg_b;
   logic signed [acc_cpu_pkg::WORD_W-1:0] stack_pointer;
   logic signed [acc_cpu_pkg::WORD_W-1:0] program_counter;

   modport source(output valid, output status, output reg_a, output reg_b,
                  output stack_pointer, output program_counter, input ready);
   modport sink(input valid, input status, input reg_a, input reg_b,
                input stack_pointer, input program_counter, output ready);
endinterface

interface acc_cpu_csr_if;
   logic                              valid;
   logic                              ready;
   logic [acc_cpu_pkg::PLEN_W-1:0]    program_length;

   modport source(output valid, output program_length, input ready);
   modport sink(input valid, input program_length, output ready);
endinterface

// ----- design/acc_cpu_ram.sv -----
module acc_cpu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/acc_cpu_exec.sv -----
module acc_cpu_exec (
   input  acc_cpu_pkg::req_item_type           item,
   input  acc_cpu_pkg::cpu_state_type          cur,
   input  logic [acc_cpu_pkg::PLEN_W-1:0]      prog_length,
   input  logic                                addr_ok,
   input  logic [acc_cpu_pkg::MEM_ADDR_W-1:0]  daddr,
   input  logic [acc_cpu_pkg::WORD_W-1:0]      rd_data,
   output acc_cpu_pkg::cpu_state_type          nxt,
   output acc_cpu_pkg::mem_wr_type             mem_wr
);

   always_comb begin
      logic [acc_cpu_pkg::WORD_W-1:0] un;
      logic [acc_cpu_pkg::WORD_W-1:0] plen;
      logic [acc_cpu_pkg::WORD_W-1:0] next_pc;
      logic                           post;

      un      = acc_cpu_pkg::WORD_W'(item.instr_operand);
      plen    = acc_cpu_pkg::WORD_W'(prog_length);
      next_pc = cur.pc + 32'd1;
      post    = 1'b0;
      nxt     = cur;
      mem_wr  = '0;

      case (item.operation)
         acc_cpu_pkg::OPN_LOAD: begin
            if (32'(item.load_address) < 32'(acc_cpu_pkg::MEM_DEPTH)) begin
               mem_wr.en   = 1'b1;
               mem_wr.addr = acc_cpu_pkg::MEM_ADDR_W'(item.load_address);
               mem_wr.data = item.load_data;
            end
         end
         acc_cpu_pkg::OPN_EXEC, acc_cpu_pkg::OPN_SKIP: begin
            if (cur.status == acc_cpu_pkg::ST_RUN) begin
               if (cur.pc[acc_cpu_pkg::WORD_W-1]) begin
                  nxt.status = acc_cpu_pkg::ST_FAULT;
               end else if (cur.pc >= plen) begin
                  nxt.status = acc_cpu_pkg::ST_END;
               end else if (item.operation == acc_cpu_pkg::OPN_SKIP) begin
                  nxt.pc = next_pc;
                  post   = 1'b1;
               end else begin
                  post = 1'b1;
                  case (item.instr_opcode)
                     acc_cpu_pkg::OPC_LDC: begin
                        nxt.b = cur.a;
                        nxt.a = un;
                     end
                     acc_cpu_pkg::OPC_ADC: nxt.a = cur.a + un;
                     acc_cpu_pkg::OPC_LDL: begin
                        if (addr_ok) begin
                           nxt.b = cur.a;
                           nxt.a = rd_data;
                        end
                     end
                     acc_cpu_pkg::OPC_STL: begin
                        if (addr_ok) begin
                           mem_wr.en   = 1'b1;
                           mem_wr.addr = daddr;
                           mem_wr.data = cur.a;
                           nxt.a       = cur.b;
                        end
                     end
                     acc_cpu_pkg::OPC_LDNL: begin
                        if (addr_ok) begin
                           nxt.a = rd_data;
                        end
                     end
                     acc_cpu_pkg::OPC_STNL: begin
                        if (addr_ok) begin
                           mem_wr.en   = 1'b1;
                           mem_wr.addr = daddr;
                           mem_wr.data = cur.b;
                        end
                     end
                     acc_cpu_pkg::OPC_ADD: nxt.a = cur.b + cur.a;
                     acc_cpu_pkg::OPC_SUB: nxt.a = cur.b - cur.a;
                     acc_cpu_pkg::OPC_SHL: nxt.a = {cur.b[30:0], 1'b0};
                     acc_cpu_pkg::OPC_SHR: nxt.a = {cur.b[31], cur.b[31:1]};
                     acc_cpu_pkg::OPC_ADJ: nxt.sp = cur.sp + un;
                     acc_cpu_pkg::OPC_A2SP: begin
                        nxt.sp = cur.a;
                        nxt.a  = cur.b;
                     end
                     acc_cpu_pkg::OPC_SP2A: begin
                        nxt.b = cur.a;
                        nxt.a = cur.sp;
                     end
                     acc_cpu_pkg::OPC_CALL: begin
                        nxt.b   = cur.a;
                        nxt.a   = cur.pc;
                        next_pc = un;
                     end
                     acc_cpu_pkg::OPC_RETURN: begin
                        next_pc = cur.a + 32'd1;
                        nxt.a   = cur.b;
                     end
                     acc_cpu_pkg::OPC_BRZ: begin
                        if (cur.a == '0) begin
                           next_pc = un;
                        end
                     end
                     acc_cpu_pkg::OPC_BRLZ: begin
                        if (cur.a[31]) begin
                           next_pc = un;
                        end
                     end
                     acc_cpu_pkg::OPC_BR:   next_pc = un;
                     acc_cpu_pkg::OPC_HALT: next_pc = plen + 32'd1;
                     default: begin
                        nxt.status = acc_cpu_pkg::ST_BADOP;
                        post       = 1'b0;
                     end
                  endcase
                  if ((item.instr_opcode inside {acc_cpu_pkg::OPC_LDL, acc_cpu_pkg::OPC_STL,
                                                 acc_cpu_pkg::OPC_LDNL,
                                                 acc_cpu_pkg::OPC_STNL}) && !addr_ok) begin
                     nxt.status = acc_cpu_pkg::ST_FAULT;
                     post       = 1'b0;
                  end
                  if (post) begin
                     nxt.pc = next_pc;
                  end
               end
               if (post) begin
                  if (nxt.pc[acc_cpu_pkg::WORD_W-1]) begin
                     nxt.status = acc_cpu_pkg::ST_FAULT;
                  end else if (nxt.pc >= plen) begin
                     nxt.status = acc_cpu_pkg::ST_END;
                  end
               end
            end
         end
         default: ;
      endcase
   end

endmodule

// ----- design/accumulator_cpu_execute.sv -----
// Execute unit of a two-register accumulator machine (A, B, SP, PC) with a
// 4096-word data memory held in a synchronous RAM. Each request transfer is
// a preload, an empty slot or one instruction, and returns exactly one
// response carrying the status and all four registers after it. An item
// passes an address stage, which forms the data address and reads the RAM,
// then an execute stage, which executes, writes back and loads the response.
// The next item is taken once the previous one has left the address stage,
// so a new item can be accepted while the previous one executes; a response
// that waits stalls execution but one more item is still accepted. After
// reset the block zeroes all 4096 words of the data memory, one word per
// cycle, and takes no requests during that pass; program_length writes are
// taken at any time. A nonzero status is sticky until reset.
module accumulator_cpu_execute (
   input  logic          clock,
   input  logic          reset,
   acc_cpu_req_if.sink   req,
   acc_cpu_rsp_if.source rsp,
   acc_cpu_csr_if.sink   csr
);

   logic                                 clear_ff;
   logic                                 clear_in;
   logic [acc_cpu_pkg::MEM_ADDR_W-1:0]   clear_addr_ff;
   logic [acc_cpu_pkg::MEM_ADDR_W-1:0]   clear_addr_in;
   logic [acc_cpu_pkg::PLEN_W-1:0]       plen_ff;
   logic [acc_cpu_pkg::PLEN_W-1:0]       plen_in;

   logic                                 s1_valid_ff;
   logic                                 s1_valid_in;
   acc_cpu_pkg::req_item_type            s1_item_ff;
   logic                                 s2_valid_ff;
   logic                                 s2_valid_in;
   acc_cpu_pkg::req_item_type            s2_item_ff;
   logic                                 s2_addr_ok_ff;
   logic [acc_cpu_pkg::MEM_ADDR_W-1:0]   s2_daddr_ff;
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   acc_cpu_pkg::cpu_state_type           state_ff;
   acc_cpu_pkg::cpu_state_type           state_in;

   acc_cpu_pkg::req_item_type            req_item;
   acc_cpu_pkg::cpu_state_type           exec_nxt;
   acc_cpu_pkg::mem_wr_type              mem_wr;
   logic                                 req_xfer;
   logic                                 s1_adv;
   logic                                 s2_done;
   logic [acc_cpu_pkg::WORD_W-1:0]       addr_base;
   logic signed [acc_cpu_pkg::WORD_W:0]  addr_sum;
   logic                                 addr_ok;
   logic [acc_cpu_pkg::WORD_W-1:0]       rd_data;
   logic                                 ram_wr_en;
   logic [acc_cpu_pkg::MEM_ADDR_W-1:0]   ram_wr_addr;
   logic [acc_cpu_pkg::WORD_W-1:0]       ram_wr_data;

   assign req_item.operation     = req.operation;
   assign req_item.instr_opcode  = req.instr_opcode;
   assign req_item.instr_operand = req.instr_operand;
   assign req_item.load_address  = req.load_address;
   assign req_item.load_data     = req.load_data;

   assign req.ready = !clear_ff && !s1_valid_ff;
   assign csr.ready = 1'b1;
   assign req_xfer  = req.valid && req.ready;
   // address stage waits for the execute stage to drain so A and SP are current
   assign s1_adv    = s1_valid_ff && !s2_valid_ff;
   assign s2_done   = s2_valid_ff && (!rsp_valid_ff || rsp.ready);

   assign addr_base = (s1_item_ff.instr_opcode inside {acc_cpu_pkg::OPC_LDL,
                                                       acc_cpu_pkg::OPC_STL}) ?
                      state_ff.sp : state_ff.a;
   assign addr_sum  = (acc_cpu_pkg::WORD_W+1)'(signed'(addr_base)) +
                      (acc_cpu_pkg::WORD_W+1)'(s1_item_ff.instr_operand);
   assign addr_ok   = !addr_sum[acc_cpu_pkg::WORD_W] &&
                      (addr_sum[acc_cpu_pkg::WORD_W-1:0] < 32'(acc_cpu_pkg::MEM_DEPTH));

   acc_cpu_exec u_exec (
      .item        (s2_item_ff),
      .cur         (state_ff),
      .prog_length (plen_ff),
      .addr_ok     (s2_addr_ok_ff),
      .daddr       (s2_daddr_ff),
      .rd_data     (rd_data),
      .nxt         (exec_nxt),
      .mem_wr      (mem_wr)
   );

   assign ram_wr_en   = clear_ff || (s2_done && mem_wr.en);
   assign ram_wr_addr = clear_ff ? clear_addr_ff : mem_wr.addr;
   assign ram_wr_data = clear_ff ? '0 : mem_wr.data;

   acc_cpu_ram #(
      .WIDTH (acc_cpu_pkg::WORD_W),
      .DEPTH (acc_cpu_pkg::MEM_DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (s1_adv),
      .rd_addr (addr_sum[acc_cpu_pkg::MEM_ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == acc_cpu_pkg::MEM_ADDR_W'(acc_cpu_pkg::MEM_DEPTH - 1)) begin
            clear_in = 1'b0;
         end
      end
      plen_in      = (csr.valid && csr.ready) ? csr.program_length : plen_ff;
      s1_valid_in  = req_xfer || (s1_valid_ff && !s1_adv);
      s2_valid_in  = s1_adv || (s2_valid_ff && !s2_done);
      rsp_valid_in = s2_done || (rsp_valid_ff && !rsp.ready);
      state_in     = s2_done ? exec_nxt : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         plen_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         plen_ff       <= plen_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_item_ff <= req_item;
      end
      if (s1_adv) begin
         s2_item_ff    <= s1_item_ff;
         s2_addr_ok_ff <= addr_ok;
         s2_daddr_ff   <= addr_sum[acc_cpu_pkg::MEM_ADDR_W-1:0];
      end
   end

   // response payload is the architectural state; it only moves on s2_done
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = state_ff.status;
   assign rsp.reg_a           = signed'(state_ff.a);
   assign rsp.reg_b           = signed'(state_ff.b);
   assign rsp.stack_pointer   = signed'(state_ff.sp);
   assign rsp.program_counter = signed'(state_ff.pc);

`ifndef ASSERT_OFF
   a_done_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      s2_done |=> rsp_valid_ff)
      else $error("execute completed without a response");

   a_adv_fills_s2: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> s2_valid_ff && !$past(s2_valid_ff))
      else $error("address stage advanced into a busy execute stage");

   a_status_sticky: assert property (@(posedge clock) disable iff (reset)
      (state_ff.status != acc_cpu_pkg::ST_RUN) |=> state_ff.status == $past(state_ff.status))
      else $error("nonzero status changed");

   a_clear_full: assert property (@(posedge clock) disable iff (reset)
      $fell(clear_ff) |->
         $past(clear_addr_ff) == acc_cpu_pkg::MEM_ADDR_W'(acc_cpu_pkg::MEM_DEPTH - 1))
      else $error("memory clear ended early");

   a_no_exec_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !s1_valid_ff && !s2_valid_ff)
      else $error("item in flight during memory clear");
`endif

endmodule
